// ----- design/block_buffer_cache_lru_assert.svh -----
// Assertion macros for the buffer cache checker.
`ifndef BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH

// ante implies cons in the same cycle
`define LBC_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lbc assertion failed");

// ante implies cons in the next cycle
`define LBC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lbc assertion failed");

`endif

// ----- design/lbc_pkg.sv -----
`timescale 1ns / 1ps
package lbc_pkg;

  localparam int TYPE_W   = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int IDX_W    = 5;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 16;

  localparam logic [TYPE_W-1:0] REQ_GET     = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_PIN     = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_UNPIN   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] op;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [IDX_W-1:0]  idx;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] id;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic             valid;
    logic [CNT_W-1:0] count;
  } entry_t;

  // search token walking the chain from rank 0 upward
  typedef struct packed {
    logic             vld;
    logic             match;
    logic [POS_W-1:0] m_pos;
    entry_t           m_ent;
    logic             free;
    logic [POS_W-1:0] f_pos;
    logic [POS_W-1:0] f_id;
  } scan_t;

  // update broadcast to all cells
  typedef struct packed {
    logic             en;
    logic             shift;
    logic [POS_W-1:0] pos;
    entry_t           ent;
  } cmd_t;

endpackage

// ----- design/lbc_if.sv -----
`timescale 1ns / 1ps
interface lbc_req_if;
  logic                            valid;
  logic                            ready;
  logic [lbc_pkg::TYPE_W-1:0]      req_type;
  logic [lbc_pkg::DEV_W-1:0]       device_id;
  logic [lbc_pkg::BLK_W-1:0]       block_number;
  logic [lbc_pkg::IDX_W-1:0]       entry_index;

  modport source (output valid, req_type, device_id, block_number, entry_index,
                  input ready);
  modport sink (input valid, req_type, device_id, block_number, entry_index,
                output ready);
endinterface

interface lbc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lbc_pkg::IDX_W-1:0]       result_index;
  logic                            hit;
  logic                            needs_read;
  logic [lbc_pkg::STATUS_W-1:0]    status;

  modport source (output valid, result_index, hit, needs_read, status,
                  input ready);
  modport sink (input valid, result_index, hit, needs_read, status,
                output ready);
endinterface

// ----- design/block_buffer_cache_lru.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload                                          Transfer
// req      in   req_type, device_id, block_number, entry_index   valid & ready
// rsp      out  result_index, hit, needs_read, status            valid & ready
//
// One request is handled at a time: the token walks the cell chain one cell per
// cycle in recency order, then fin latches it and the result register takes the
// result once it is free; rsp turns valid when that register is loaded.
// A result waiting on rsp does not block the next request transfer.
// Reset is synchronous; tags clear, recency order is entry N-1 first.
// A stalled rsp holds the update until the result register frees up.
module block_buffer_cache_lru #(
  parameter int NUM_ENTRIES = 32,
  parameter int COUNT_BITS  = 8
) (
  input logic         clk,
  input logic         rst,
  lbc_req_if.sink     req,
  lbc_rsp_if.source   rsp
);

  localparam int CW = lbc_pkg::CNT_W;
  localparam int IXW = lbc_pkg::IDX_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  lbc_pkg::req_t                 req_q;
  logic                          launch;
  lbc_pkg::scan_t                fin;
  lbc_pkg::scan_t                launch_tok;
  lbc_pkg::cmd_t                 cmd;
  lbc_pkg::cmd_t                 cmd_body;
  lbc_pkg::scan_t                toks [NUM_ENTRIES];
  lbc_pkg::entry_t               ents [NUM_ENTRIES];
  logic                          accept;
  logic                          go;
  logic [COUNT_BITS-1:0]         cnt;
  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [COUNT_BITS-1:0]         cnt_dec;
  logic [IXW-1:0]                res_idx;
  logic                          res_hit;
  logic                          res_rd;
  logic [lbc_pkg::STATUS_W-1:0]  res_status;
  logic                          out_vld;
  logic [IXW-1:0]                out_idx;
  logic                          out_hit;
  logic                          out_rd;
  logic [lbc_pkg::STATUS_W-1:0]  out_status;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign go        = (state == ST_DONE) && (!out_vld || rsp.ready);

  always_comb begin
    launch_tok     = '0;
    launch_tok.vld = launch;
  end

  genvar k;
  generate
    for (k = 0; k < NUM_ENTRIES; k++) begin : g_cell
      lbc_pkg::scan_t  t_in;
      lbc_pkg::entry_t p_in;
      if (k == 0) begin : g_head
        assign t_in = launch_tok;
        assign p_in = cmd.ent;
      end else begin : g_body
        assign t_in = toks[k-1];
        assign p_in = ents[k-1];
      end
      lbc_cell #(
        .NUM_ENTRIES(NUM_ENTRIES), .COUNT_BITS(COUNT_BITS), .POS(k)
      ) u_cell (
        .clk(clk), .rst(rst), .req(req_q), .tok_in(t_in), .tok_out(toks[k]),
        .cmd(cmd), .prev(p_in), .ent(ents[k])
      );
    end
  endgenerate

  assign cnt     = fin.m_ent.count[COUNT_BITS-1:0];
  assign cnt_inc = cnt + 1'b1;
  assign cnt_dec = cnt - 1'b1;

  always_comb begin
    cmd_body   = '0;
    res_idx    = req_q.idx;
    res_hit    = 1'b0;
    res_rd     = 1'b0;
    res_status = lbc_pkg::STATUS_OK;
    if (req_q.op == lbc_pkg::REQ_GET) begin
      if (fin.match) begin
        res_idx = fin.m_ent.id[IXW-1:0];
        res_hit = 1'b1;
        if (cnt == CNT_MAX) begin
          res_status = lbc_pkg::STATUS_OVERFLOW;
        end else begin
          res_rd              = !fin.m_ent.valid;
          cmd_body.en         = 1'b1;
          cmd_body.pos        = fin.m_pos;
          cmd_body.ent        = fin.m_ent;
          cmd_body.ent.valid  = 1'b1;
          cmd_body.ent.count  = CW'(cnt_inc);
        end
      end else if (fin.free) begin
        res_idx            = fin.f_id[IXW-1:0];
        res_rd             = 1'b1;
        cmd_body.en        = 1'b1;
        cmd_body.pos       = fin.f_pos;
        cmd_body.ent.id    = fin.f_id;
        cmd_body.ent.dev   = req_q.dev;
        cmd_body.ent.blk   = req_q.blk;
        cmd_body.ent.valid = 1'b1;
        cmd_body.ent.count = CW'(1);
      end else begin
        res_idx    = '0;
        res_status = lbc_pkg::STATUS_NO_FREE;
      end
    end else if (fin.match) begin
      cmd_body.pos = fin.m_pos;
      cmd_body.ent = fin.m_ent;
      if (req_q.op == lbc_pkg::REQ_PIN) begin
        if (cnt == CNT_MAX) begin
          res_status = lbc_pkg::STATUS_OVERFLOW;
        end else begin
          cmd_body.en        = 1'b1;
          cmd_body.ent.count = CW'(cnt_inc);
        end
      end else if (cnt == '0) begin
        res_status = lbc_pkg::STATUS_UNDERFLOW;
      end else begin
        cmd_body.en        = 1'b1;
        cmd_body.ent.count = CW'(cnt_dec);
        // last release: move to the head of the chain
        cmd_body.shift     = (req_q.op == lbc_pkg::REQ_RELEASE) && (cnt_dec == '0);
      end
    end
    cmd    = cmd_body;
    cmd.en = cmd_body.en && go;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (toks[NUM_ENTRIES-1].vld) state_next = ST_DONE;
      ST_DONE: if (go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      launch  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
      if (go) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.op  <= req.req_type;
      req_q.dev <= req.device_id;
      req_q.blk <= req.block_number;
      req_q.idx <= req.entry_index;
    end
    if (toks[NUM_ENTRIES-1].vld) begin
      fin <= toks[NUM_ENTRIES-1];
    end
    if (go) begin
      out_idx    <= res_idx;
      out_hit    <= res_hit;
      out_rd     <= res_rd;
      out_status <= res_status;
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.result_index = out_idx;
  assign rsp.hit          = out_hit;
  assign rsp.needs_read   = out_rd;
  assign rsp.status       = out_status;

endmodule

// ----- design/lbc_cell.sv -----
`timescale 1ns / 1ps
module lbc_cell #(
  parameter int NUM_ENTRIES = 32,
  parameter int COUNT_BITS  = 8,
  parameter int POS         = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  lbc_pkg::req_t    req,
  input  lbc_pkg::scan_t   tok_in,
  output lbc_pkg::scan_t   tok_out,
  input  lbc_pkg::cmd_t    cmd,
  input  lbc_pkg::entry_t  prev,
  output lbc_pkg::entry_t  ent
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int PW = lbc_pkg::POS_W;
  localparam int CW = lbc_pkg::CNT_W;

  logic [IW-1:0]              id;
  logic [lbc_pkg::DEV_W-1:0]  dev;
  logic [lbc_pkg::BLK_W-1:0]  blk;
  logic                       valid;
  logic [COUNT_BITS-1:0]      count;
  lbc_pkg::scan_t             tok;
  lbc_pkg::scan_t             tok_next;
  lbc_pkg::entry_t            src;
  logic                       hit_here;
  logic                       take_cmd;
  logic                       take_prev;

  always_comb begin
    ent.id    = PW'(id);
    ent.dev   = dev;
    ent.blk   = blk;
    ent.valid = valid;
    ent.count = CW'(count);
  end

  always_comb begin
    if (req.op == lbc_pkg::REQ_GET) begin
      hit_here = (dev == req.dev) && (blk == req.blk);
    end else begin
      hit_here = (PW'(id) == PW'(req.idx));
    end
    tok_next = tok_in;
    if (tok_in.vld) begin
      if (hit_here && !tok_in.match) begin
        tok_next.match = 1'b1;
        tok_next.m_pos = PW'(POS);
        tok_next.m_ent = ent;
      end
      // last free cell seen is the least recent one
      if (count == '0) begin
        tok_next.free  = 1'b1;
        tok_next.f_pos = PW'(POS);
        tok_next.f_id  = PW'(id);
      end
    end
  end

  assign take_cmd  = cmd.en && !cmd.shift && (cmd.pos == PW'(POS));
  assign take_prev = cmd.en && cmd.shift && (PW'(POS) <= cmd.pos);
  assign src       = take_cmd ? cmd.ent : prev;
  assign tok_out   = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      id    <= IW'(NUM_ENTRIES - 1 - POS);
      dev   <= '0;
      blk   <= '0;
      valid <= 1'b0;
      count <= '0;
      tok   <= '0;
    end else begin
      tok <= tok_next;
      if (take_cmd || take_prev) begin
        id    <= src.id[IW-1:0];
        dev   <= src.dev;
        blk   <= src.blk;
        valid <= src.valid;
        count <= src.count[COUNT_BITS-1:0];
      end
    end
  end

endmodule

// ----- design/lbc_checker.sv -----
`timescale 1ns / 1ps
`include "block_buffer_cache_lru_assert.svh"
module lbc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [lbc_pkg::IDX_W-1:0]     rsp_index,
  input logic                          rsp_hit,
  input logic                          rsp_read,
  input logic [lbc_pkg::STATUS_W-1:0]  rsp_status
);

  `LBC_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)
  `LBC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_index) && $stable(rsp_status))
  `LBC_ASSERT_NOW(a_read_ok, clk, rst, rsp_valid && rsp_read, rsp_status == lbc_pkg::STATUS_OK)
  `LBC_ASSERT_NOW(a_no_free, clk, rst, rsp_valid && rsp_status == lbc_pkg::STATUS_NO_FREE,
                  rsp_index == '0 && !rsp_hit && !rsp_read)

endmodule

bind block_buffer_cache_lru lbc_checker u_lbc_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_index(rsp.result_index),
  .rsp_hit(rsp.hit),
  .rsp_read(rsp.needs_read),
  .rsp_status(rsp.status)
);
